### rtl/core/ufs_pkg.sv
package ufs_pkg;

  localparam int UFS_MAX_URL_BYTES = 1024;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MAL  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  localparam logic [1:0] PART_SCHEMA = 2'd0;
  localparam logic [1:0] PART_HOST   = 2'd1;
  localparam logic [1:0] PART_PATH   = 2'd2;
  localparam logic [1:0] PART_QUERY  = 2'd3;

  localparam int BIT_SCHEMA = 0;
  localparam int BIT_HOST   = 1;
  localparam int BIT_PORT   = 2;
  localparam int BIT_PATH   = 3;
  localparam int BIT_QUERY  = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       last;
  } ufs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  present_mask;
    logic [9:0]  schema_offset;
    logic [10:0] schema_length;
    logic [9:0]  host_offset;
    logic [10:0] host_length;
    logic [15:0] port_number;
    logic [9:0]  path_offset;
    logic [10:0] path_length;
    logic [9:0]  query_offset;
    logic [10:0] query_length;
  } ufs_out_t;

endpackage

### rtl/core/ufs_parser.sv
module ufs_parser import ufs_pkg::*; #(
  parameter int MAX_URL_BYTES = UFS_MAX_URL_BYTES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  ufs_in_t  item,
  output logic     emit,
  output ufs_out_t result
);

  localparam int OFS_W = $clog2(MAX_URL_BYTES + 1);
  localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_URL_BYTES);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_SCHEMA = 3'd1;
  localparam logic [2:0] PH_SLASH  = 3'd2;
  localparam logic [2:0] PH_HOST   = 3'd3;
  localparam logic [2:0] PH_PORT   = 3'd4;
  localparam logic [2:0] PH_PATH   = 3'd5;
  localparam logic [2:0] PH_QUERY  = 3'd6;

  logic [2:0]       phase, phase_next, w_phase;
  logic [OFS_W-1:0] ofs, ofs_next, w_ofs;
  logic             skip, skip_next;
  logic [4:0]       present, present_next, w_present;
  logic [OFS_W-1:0] offs [4];
  logic [OFS_W-1:0] offs_next [4];
  logic [OFS_W-1:0] w_offs [4];
  logic [OFS_W-1:0] lens [4];
  logic [OFS_W-1:0] lens_next [4];
  logic [OFS_W-1:0] w_lens [4];
  logic [15:0]      port, port_next, w_port;

  logic [7:0]       c;
  logic [7:0]       low_c;
  logic             is_blank, is_letter, is_digit;
  logic [19:0]      port_sum;
  logic             fail, done, close_en;
  logic [OFS_W-1:0] close_end;
  logic [1:0]       status;

  function automatic logic [9:0] fit10(input logic [OFS_W-1:0] v);
    logic [OFS_W+9:0] w;
    w = {10'd0, v};
    return w[9:0];
  endfunction

  function automatic logic [10:0] fit11(input logic [OFS_W-1:0] v);
    logic [OFS_W+10:0] w;
    w = {11'd0, v};
    return w[10:0];
  endfunction

  assign c         = item.url_byte;
  assign low_c     = c | CH_SPACE;
  assign is_blank  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_letter = (low_c >= CH_LA) && (low_c <= CH_LZ);
  assign is_digit  = (c >= CH_D0) && (c <= CH_D9);
  assign port_sum  = 20'({port, 3'b000}) + 20'({port, 1'b0}) + 20'(c - CH_D0);

  always_comb begin
    w_phase   = phase;
    w_ofs     = ofs;
    w_present = present;
    w_offs    = offs;
    w_lens    = lens;
    w_port    = port;
    emit      = 1'b0;
    status    = ST_OK;
    fail      = 1'b0;
    done      = 1'b0;
    close_en  = 1'b0;
    close_end = ofs;

    if (skip) begin
      emit = 1'b0;
    end else if (c == CH_NUL) begin
      close_en = 1'b1;
      emit     = 1'b1;
    end else if (ofs >= MAX_OFS) begin
      emit   = 1'b1;
      status = ST_LONG;
    end else begin
      w_ofs = ofs + 1'b1;
      unique case (phase)
        PH_START: begin
          if (is_blank) begin
            w_phase = PH_START;
          end else if (is_letter) begin
            w_offs[PART_SCHEMA] = ofs;
            w_phase = PH_SCHEMA;
          end else if (c == CH_SLASH) begin
            w_offs[PART_PATH] = ofs;
            w_phase = PH_PATH;
          end else begin
            fail = 1'b1;
          end
        end
        PH_SCHEMA: begin
          if (c == CH_COLON) begin
            w_lens[PART_SCHEMA] = ofs - offs[PART_SCHEMA];
            w_present[BIT_SCHEMA] = 1'b1;
            w_phase = PH_SLASH;
          end else if (!is_letter) begin
            fail = 1'b1;
          end
        end
        PH_SLASH: begin
          if (is_letter) begin
            w_offs[PART_HOST] = ofs;
            w_phase = PH_HOST;
          end else if (c != CH_SLASH) begin
            fail = 1'b1;
          end
        end
        PH_HOST: begin
          if (is_letter || is_digit || c == CH_DOT || c == CH_DASH) begin
            w_phase = PH_HOST;
          end else if (c == CH_COLON) begin
            w_lens[PART_HOST] = ofs - offs[PART_HOST];
            w_present[BIT_HOST] = 1'b1;
            w_port = 16'd0;
            w_phase = PH_PORT;
          end else if (c == CH_SLASH) begin
            w_lens[PART_HOST] = ofs - offs[PART_HOST];
            w_present[BIT_HOST] = 1'b1;
            w_offs[PART_PATH] = ofs;
            w_phase = PH_PATH;
          end else begin
            fail = 1'b1;
          end
        end
        PH_PORT: begin
          if (is_digit) begin
            w_port = (port_sum > 20'd65535) ? 16'hFFFF : port_sum[15:0];
          end else if (c == CH_SLASH) begin
            w_present[BIT_PORT] = 1'b1;
            w_offs[PART_PATH] = ofs;
            w_phase = PH_PATH;
          end else if (is_blank) begin
            w_present[BIT_PORT] = 1'b1;
            done = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        PH_PATH: begin
          if (c == CH_QMARK) begin
            w_lens[PART_PATH] = ofs - offs[PART_PATH];
            w_present[BIT_PATH] = 1'b1;
            w_offs[PART_QUERY] = w_ofs;
            w_phase = PH_QUERY;
          end else if (c == CH_HASH || is_blank) begin
            w_lens[PART_PATH] = ofs - offs[PART_PATH];
            w_present[BIT_PATH] = 1'b1;
            done = 1'b1;
          end
        end
        PH_QUERY: begin
          if (c == CH_HASH || is_blank) begin
            w_lens[PART_QUERY] = ofs - offs[PART_QUERY];
            w_present[BIT_QUERY] = 1'b1;
            done = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase

      if (fail) begin
        emit   = 1'b1;
        status = ST_MAL;
      end else if (done) begin
        emit = 1'b1;
      end else if (item.last) begin
        close_en  = 1'b1;
        close_end = w_ofs;
        emit      = 1'b1;
      end
    end

    if (close_en) begin
      unique case (w_phase)
        PH_SCHEMA: begin
          w_lens[PART_SCHEMA] = close_end - w_offs[PART_SCHEMA];
          w_present[BIT_SCHEMA] = 1'b1;
        end
        PH_HOST: begin
          w_lens[PART_HOST] = close_end - w_offs[PART_HOST];
          w_present[BIT_HOST] = 1'b1;
        end
        PH_PORT: begin
          w_present[BIT_PORT] = 1'b1;
        end
        PH_PATH: begin
          w_lens[PART_PATH] = close_end - w_offs[PART_PATH];
          w_present[BIT_PATH] = 1'b1;
        end
        PH_QUERY: begin
          w_lens[PART_QUERY] = close_end - w_offs[PART_QUERY];
          w_present[BIT_QUERY] = 1'b1;
        end
        default: begin
          w_present = w_present;
        end
      endcase
    end
  end

  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.present_mask = w_present;
      if (w_present[BIT_SCHEMA]) begin
        result.schema_offset = fit10(w_offs[PART_SCHEMA]);
        result.schema_length = fit11(w_lens[PART_SCHEMA]);
      end
      if (w_present[BIT_HOST]) begin
        result.host_offset = fit10(w_offs[PART_HOST]);
        result.host_length = fit11(w_lens[PART_HOST]);
      end
      if (w_present[BIT_PORT]) begin
        result.port_number = w_port;
      end
      if (w_present[BIT_PATH]) begin
        result.path_offset = fit10(w_offs[PART_PATH]);
        result.path_length = fit11(w_lens[PART_PATH]);
      end
      if (w_present[BIT_QUERY]) begin
        result.query_offset = fit10(w_offs[PART_QUERY]);
        result.query_length = fit11(w_lens[PART_QUERY]);
      end
    end
  end

  always_comb begin
    if (item.last && (skip || emit)) begin
      phase_next   = PH_START;
      ofs_next     = '0;
      skip_next    = 1'b0;
      present_next = '0;
      port_next    = '0;
      for (int k = 0; k < 4; k++) begin
        offs_next[k] = '0;
        lens_next[k] = '0;
      end
    end else begin
      phase_next   = w_phase;
      ofs_next     = w_ofs;
      skip_next    = skip | emit;
      present_next = w_present;
      port_next    = w_port;
      offs_next    = w_offs;
      lens_next    = w_lens;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_START;
      ofs     <= '0;
      skip    <= 1'b0;
      present <= '0;
      port    <= '0;
      for (int k = 0; k < 4; k++) begin
        offs[k] <= '0;
        lens[k] <= '0;
      end
    end else if (step) begin
      phase   <= phase_next;
      ofs     <= ofs_next;
      skip    <= skip_next;
      present <= present_next;
      port    <= port_next;
      offs    <= offs_next;
      lens    <= lens_next;
    end
  end

  a_ofs_bound: assert property (@(posedge clk) disable iff (rst)
    ofs <= MAX_OFS)
    else $error("byte offset past limit");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    skip |-> !emit)
    else $error("result while skipping");

  a_skip_hold: assert property (@(posedge clk) disable iff (rst)
    (step && skip && !item.last) |=> skip)
    else $error("skipping ended without last flag");

endmodule

### rtl/core/url_field_splitter_top.sv
// Path: an accepted byte is held in the input register, where the parser reads it;
// its result, if any, is registered into the output register and shown on result.
// Throughput: one byte per cycle; the input stalls only while a result waits
// in the output register and the byte in the input register would make another.
// Reset (rst, synchronous): empties both registers and returns the parser to
// its start phase with offsets, lengths and port cleared.
module url_field_splitter_top import ufs_pkg::*; #(
  parameter int MAX_URL_BYTES = UFS_MAX_URL_BYTES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  ufs_in_t  item,
  output logic     result_valid,
  input  logic     result_stall,
  output ufs_out_t result
);

  logic     s1_valid;
  ufs_in_t  s1_item;
  logic     emit;
  ufs_out_t res_comb;
  logic     out_free;
  logic     advance;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = s1_valid && (!emit || out_free);
  assign item_stall = s1_valid && !advance;

  ufs_parser #(
    .MAX_URL_BYTES(MAX_URL_BYTES)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (s1_item),
    .emit  (emit),
    .result(res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result <= res_comb;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(advance && emit && result_valid && result_stall))
    else $error("held result overwritten");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && emit && result_valid))
    else $error("input stalled without cause");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> result_valid)
    else $error("result lost");

  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |-> (result.present_mask == 5'd0))
    else $error("failed result carries fields");

endmodule
